### hw/rtl/wam_pkg.sv
// shared constants, types and helpers for the windowed and running mean core
// no dependencies; imported by every module of the block except wam_div
`default_nettype none

package wam_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 9;
  localparam int TOTAL_W        = 64;
  localparam int COUNT_W        = 32;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int WINDOW_LEN_RST = 25;
  localparam int Q_DEPTH        = 2;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // clamp a 64-bit signed value to the signed 32-bit range
  function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [TOTAL_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > TOTAL_W'(64'sh0000_0000_7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wam_div.sv
// radix-2 restoring divider, signed dividend by positive unsigned divisor
// quotient truncates toward zero; one quotient bit per cycle; no package use
`default_nettype none

module wam_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] dividend,
  input  wire logic        [DW-1:0] divisor,
  output logic                      busy,
  output logic signed [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dsr;
  logic          neg;

  logic [DW:0]   rem_shift;
  logic [DW+1:0] diff;
  logic          fits;

  assign rem_shift = {rem, quo[NW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dsr};
  assign fits      = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[NW-1];
      // magnitude; the most negative value maps onto its unsigned pattern
      quo <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : rem_shift[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

`default_nettype wire

### hw/rtl/wam_queue.sv
// short job queue between the front and back parts
// register based, Q_DEPTH entries; uses wam_pkg
`default_nettype none

module wam_queue
  import wam_pkg::*;
#(
  parameter int W = 128
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      head
);

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  logic [W-1:0]  slots [Q_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign full  = (fill == NW'(Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wam_front.sv
// front part: takes samples, keeps the sample ring and the running sums,
// and queues one division job per sample; uses wam_pkg
`default_nettype none

module wam_front
  import wam_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SUM_W      = SAMPLE_W + 8,
  parameter int JOB_W      = SUM_W + CFG_W + TOTAL_W + COUNT_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            push,
  output logic [JOB_W-1:0]                push_data,
  input  wire logic                       queue_full
);

  localparam int POS_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WL_RST = (WINDOW_LEN_RST > WINDOW_MAX) ? WINDOW_MAX : WINDOW_LEN_RST;

  front_state_t state, state_next;

  logic [SAMPLE_W-1:0]        ring [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] old_q;
  logic [POS_W-1:0]           pos;
  logic [CFG_W-1:0]           wl;
  logic signed [SUM_W-1:0]    window_sum;
  logic signed [TOTAL_W-1:0]  total_sum;
  logic [COUNT_W-1:0]         total_count;

  logic                       accept;
  logic                       update;
  logic [POS_W-1:0]           pos_eff;
  logic [POS_W-1:0]           pos_wrap;
  logic [COUNT_W-1:0]         count_next;
  logic                       window_full;
  logic [CFG_W-1:0]           wdiv;
  logic signed [SAMPLE_W:0]   delta;
  logic signed [SUM_W-1:0]    window_sum_next;
  logic signed [TOTAL_W:0]    total_wide;
  logic signed [TOTAL_W-1:0]  total_sum_next;

  assign accept = sample_valid && !sample_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:   if (accept) state_next = F_UPDATE;
      F_UPDATE: if (!queue_full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    update       = 1'b0;
    unique case (state)
      F_IDLE:   sample_stall = 1'b0;
      F_UPDATE: update = !queue_full;
      default:  sample_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // position guard and wrap
  assign pos_eff  = (32'(pos) >= 32'(wl)) ? '0 : pos;
  assign pos_wrap = (32'(pos_eff) + 32'd1 >= 32'(wl)) ? '0 : pos_eff + POS_W'(1);

  assign count_next  = (total_count == '1) ? total_count : total_count + COUNT_W'(1);
  assign window_full = (count_next > COUNT_W'(wl));
  assign wdiv        = window_full ? wl : CFG_W'(32'(pos_eff) + 32'd1);

  // oldest sample leaves once the window has filled
  assign delta = window_full ? (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(old_q)
                             : (SAMPLE_W+1)'(sample_q);
  assign window_sum_next = window_sum + SUM_W'(delta);

  assign total_wide = (TOTAL_W+1)'(total_sum) + (TOTAL_W+1)'(sample_q);
  always_comb begin
    if (total_wide[TOTAL_W] != total_wide[TOTAL_W-1]) begin
      total_sum_next = total_wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                           : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      total_sum_next = total_wide[TOTAL_W-1:0];
    end
  end

  assign push      = update;
  assign push_data = {window_sum_next, wdiv, total_sum_next, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      wl          <= CFG_W'(WL_RST);
      pos         <= '0;
      window_sum  <= '0;
      total_sum   <= '0;
      total_count <= '0;
    end else if (cfg_we && (cfg_wdata != '0)) begin
      wl          <= (32'(cfg_wdata) > 32'(WINDOW_MAX)) ? CFG_W'(WINDOW_MAX) : cfg_wdata;
      pos         <= '0;
      window_sum  <= '0;
      total_sum   <= '0;
      total_count <= '0;
    end else if (update) begin
      pos         <= pos_wrap;
      window_sum  <= window_sum_next;
      total_sum   <= total_sum_next;
      total_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
      old_q    <= ring[pos_eff];
    end
    if (update) begin
      ring[pos_eff] <= sample_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wam_back.sv
// back part: runs the window and overall divisions and holds the result word
// instantiates wam_div twice; uses wam_pkg
`default_nettype none

module wam_back
  import wam_pkg::*;
#(
  parameter int SUM_W = SAMPLE_W + 8,
  parameter int JOB_W = SUM_W + CFG_W + TOTAL_W + COUNT_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               queue_empty,
  input  wire logic [JOB_W-1:0]   head,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [SAMPLE_W-1:0] window_mean,
  output logic signed [SAMPLE_W-1:0] overall_mean
);

  back_state_t state, state_next;

  logic signed [SUM_W-1:0]   job_wsum;
  logic [CFG_W-1:0]          job_wdiv;
  logic signed [TOTAL_W-1:0] job_tsum;
  logic [COUNT_W-1:0]        job_count;

  logic                      w_busy;
  logic                      o_busy;
  logic signed [SUM_W-1:0]   w_quot;
  logic signed [TOTAL_W-1:0] o_quot;
  logic                      load;
  logic                      done;

  assign job_count = head[COUNT_W-1:0];
  assign job_tsum  = head[COUNT_W +: TOTAL_W];
  assign job_wdiv  = head[COUNT_W + TOTAL_W +: CFG_W];
  assign job_wsum  = head[COUNT_W + TOTAL_W + CFG_W +: SUM_W];

  assign done = !w_busy && !o_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!queue_empty) state_next = B_RUN;
      B_RUN:   if (done && (!result_valid || !result_stall)) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      B_IDLE:  pop = !queue_empty;
      B_RUN:   load = done && (!result_valid || !result_stall);
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  wam_div #(
    .NW (SUM_W),
    .DW (CFG_W)
  ) u_wdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (pop),
    .dividend (job_wsum),
    .divisor  (job_wdiv),
    .busy     (w_busy),
    .quotient (w_quot)
  );

  wam_div #(
    .NW (TOTAL_W),
    .DW (COUNT_W)
  ) u_odiv (
    .clk      (clk),
    .rst      (rst),
    .start    (pop),
    .dividend (job_tsum),
    .divisor  (job_count),
    .busy     (o_busy),
    .quotient (o_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window_mean  <= sat32(TOTAL_W'(w_quot));
      overall_mean <= sat32(o_quot);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/windowed_and_running_mean_core.sv
// top level of the windowed and running mean core
// instantiates wam_front, wam_queue and wam_back; uses wam_pkg
//
//   channel   handshake                   payload
//   config    cfg_we                      cfg_wdata (window length)
//   input     sample_valid / sample_stall sample
//   output    result_valid / result_stall window_mean, overall_mean
//
// the front takes a sample and queues its division job before it takes the next
// each result waits for the overall mean divider, the longer of the two;
// the window mean divider runs alongside it
// a 2-entry job queue lets the front keep taking samples while the back stalls
// rst is synchronous; window length resets to 25, sums and counts to zero
`default_nettype none

module windowed_and_running_mean_core
  import wam_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic signed [SAMPLE_W-1:0]      window_mean,
  output logic signed [SAMPLE_W-1:0]      overall_mean
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int JOB_W = SUM_W + CFG_W + TOTAL_W + COUNT_W;

  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             queue_full;
  logic             pop;
  logic             queue_empty;
  logic [JOB_W-1:0] head;

  wam_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .SUM_W      (SUM_W),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .push         (push),
    .push_data    (push_data),
    .queue_full   (queue_full)
  );

  wam_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  wam_back #(
    .SUM_W (SUM_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .window_mean  (window_mean),
    .overall_mean (overall_mean)
  );

endmodule

`default_nettype wire
